// File: rtl/core/ppdm_pkg.sv
// Shared types and constants for the power to phase delay mapper.
package ppdm_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_POWER_CEILING  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORTEST_DELAY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONGEST_DELAY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_INTERCEPT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_SLOPE_Q8  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTING_MODE   = 3'd5;

    localparam logic [8:0]  RST_POWER_CEILING  = 9'd200;
    localparam logic [5:0]  RST_SHORTEST_DELAY = 6'd60;
    localparam logic [7:0]  RST_LONGEST_DELAY  = 8'd140;
    localparam logic [9:0]  RST_LINE_INTERCEPT = 10'd150;
    localparam logic signed [12:0] RST_LINE_SLOPE_Q8 = -13'sd128;

    localparam logic [8:0] OFF_DELAY = 9'd500;
    localparam int LOW_POWER   = 20;
    localparam int GAIN_STEP   = 8180;
    localparam int GAIN_MAX    = 10;
    localparam int COOL_OFFSET = 1638;
    localparam int COOL_STEP   = 3277;
    localparam int COOL_MAX    = 50;
    // floor(x / 3277) = (x * COOL_RECIP) >> COOL_SHIFT, exact for x < 2^18
    localparam int COOL_RECIP  = 327661;
    localparam int COOL_SHIFT  = 30;
    // floor(x / 10) = (x * DIV10_RECIP) >> DIV10_SHIFT, exact for x < 2^22
    localparam int DIV10_RECIP = 838861;
    localparam int DIV10_SHIFT = 23;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GAIN,
        S_MUL,
        S_DIV,
        S_AVG,
        S_LIN,
        S_UPD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load_in;
        logic gain;
        logic mul;
        logic div;
        logic avg;
        logic lin;
        logic upd;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic [8:0]         power_ceiling;
        logic [5:0]         shortest_delay;
        logic [7:0]         longest_delay;
        logic [9:0]         line_intercept;
        logic signed [12:0] line_slope_q8;
        logic               setting_mode;
    } t_cfg;

endpackage

// File: rtl/core/ppdm_ctrl.sv
// Sequencer for the power to phase delay mapper: handshakes and datapath commands.
module ppdm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ppdm_pkg::t_dp_cmd o_cmd
);
    import ppdm_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_GAIN;
            S_GAIN: n_state = S_MUL;
            S_MUL:  n_state = S_DIV;
            S_DIV:  n_state = S_AVG;
            S_AVG:  n_state = S_LIN;
            S_LIN:  n_state = S_UPD;
            S_UPD:  n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_GAIN: o_cmd.gain = 1'b1;
            S_MUL:  o_cmd.mul  = 1'b1;
            S_DIV:  o_cmd.div  = 1'b1;
            S_AVG:  o_cmd.avg  = 1'b1;
            S_LIN:  o_cmd.lin  = 1'b1;
            S_UPD:  o_cmd.upd  = 1'b1;
            S_OUT:  o_cmd.load_out = out_free;
            default: o_cmd = '0;
        endcase
    end

    assign n_out_valid = (r_out_valid && !i_out_ready) || o_cmd.load_out;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: rtl/core/ppdm_dp.sv
// Datapath for the power to phase delay mapper: gains, smoothing, delay and credit.
module ppdm_dp #(
    parameter int TIME_BITS  = 24,
    parameter int POWER_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ppdm_pkg::t_dp_cmd     i_cmd,
    input  ppdm_pkg::t_cfg        i_cfg,
    input  logic [POWER_BITS-1:0] i_power_reading,
    input  logic [TIME_BITS-1:0]  i_timestamp,
    output logic [8:0]            o_firing_delay,
    output logic [11:0]           o_smoothed_power,
    output logic                  o_firing_enabled
);
    import ppdm_pkg::*;

    localparam int PW  = POWER_BITS;
    localparam int DW  = PW + 1;
    localparam int PGW = PW + 6;
    localparam int MW  = PW + 5;
    localparam int QPW = MW + 20;
    localparam int CGW = PW + 2;
    localparam int LW  = PW + 15;

    function automatic logic signed [31:0] sat32(input logic [32:0] v);
        logic signed [31:0] res;
        if (v[32] != v[31]) begin
            res = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            res = $signed(v[31:0]);
        end
        return res;
    endfunction

    // architectural state
    logic [TIME_BITS-1:0] r_last_ts;
    logic [PW-1:0]        r_avg, n_avg;
    logic signed [31:0]   r_credit, n_credit;
    logic [8:0]           r_delay, n_delay;

    // working registers
    logic [PW-1:0]         r_reading;
    logic [TIME_BITS-1:0]  r_elapsed;
    logic [3:0]            r_gain, n_gain;
    logic [36:0]           r_cool_prod;
    logic                  r_cool_sat;
    logic signed [DW-1:0]  r_diff;
    logic signed [PGW-1:0] r_dg;
    logic [CGW-1:0]        r_cgain;
    logic [5:0]            r_cool;
    logic [QPW-1:0]        r_dg_prod;
    logic                  r_dg_neg;
    logic [14:0]           r_cc;
    logic [38:0]           r_spend_prod;
    logic signed [LW-1:0]  r_lin;
    logic [15:0]           r_spend;
    logic [8:0]            r_out_delay;
    logic [PW-1:0]         r_out_avg;

    logic [32:0]     cool_x;
    logic [PW+3:0]   cg_full;
    logic [MW-1:0]   dg_mag;
    logic [PW+1:0]   avg_step;
    logic [18:0]     cc12;
    logic [32:0]     credit_add, credit_sub;
    logic [8:0]      lin_delay, cool_delay;
    logic            above_ceiling, above_low, credit_pos;

    always_comb begin
        n_gain = '0;
        for (int k = 1; k <= GAIN_MAX; k++) begin
            if (33'(r_elapsed) >= 33'(k * GAIN_STEP)) n_gain = 4'(k);
        end
    end

    assign cool_x   = 33'(r_elapsed) + 33'(COOL_OFFSET);
    assign cg_full  = (PW+4)'(r_reading) * (PW+4)'(r_gain);
    assign dg_mag   = r_dg[PGW-1] ? MW'(-r_dg) : MW'(r_dg);
    assign avg_step = r_dg_prod[QPW-1:DIV10_SHIFT];
    assign n_avg    = r_dg_neg ? r_avg - PW'(avg_step) : r_avg + PW'(avg_step);
    assign cc12     = 19'({r_cc, 3'b000}) + 19'({r_cc, 2'b00});

    assign above_ceiling = r_avg > PW'(i_cfg.power_ceiling);
    assign above_low     = r_avg > PW'(LOW_POWER);
    assign credit_pos    = !r_credit[31] && (r_credit != 32'sd0);
    assign credit_add    = {r_credit[31], r_credit} + 33'(r_cgain);
    assign credit_sub    = {r_credit[31], r_credit} - 33'(r_spend);

    always_comb begin
        if (r_lin[LW-1]) begin
            lin_delay = 9'd0;
        end else if (r_lin[LW-2:8] > (LW-9)'(OFF_DELAY)) begin
            lin_delay = OFF_DELAY;
        end else begin
            lin_delay = r_lin[16:8];
        end
        if ({1'b0, i_cfg.longest_delay} >= {3'b000, i_cfg.shortest_delay}) begin
            cool_delay = 9'({1'b0, i_cfg.longest_delay} - {3'b000, i_cfg.shortest_delay});
        end else begin
            cool_delay = OFF_DELAY;
        end
    end

    always_comb begin
        n_delay  = r_delay;
        n_credit = r_credit;
        if (!i_cfg.setting_mode) begin
            if (above_ceiling) begin
                n_delay  = 9'(i_cfg.shortest_delay);
                n_credit = sat32(credit_add);
            end else if (above_low) begin
                n_delay  = lin_delay;
                n_credit = sat32(credit_add);
            end else if (credit_pos) begin
                n_delay  = cool_delay;
                n_credit = sat32(credit_sub);
            end else begin
                n_delay  = OFF_DELAY;
                n_credit = 32'sd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_ts <= '0;
            r_avg     <= '0;
            r_credit  <= 32'sd0;
            r_delay   <= OFF_DELAY;
        end else begin
            if (i_cmd.load_in) r_last_ts <= i_timestamp;
            if (i_cmd.avg) r_avg <= n_avg;
            if (i_cmd.upd) begin
                r_delay  <= n_delay;
                r_credit <= n_credit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_reading <= i_power_reading;
            r_elapsed <= i_timestamp - r_last_ts;
        end
        if (i_cmd.gain) begin
            r_gain      <= n_gain;
            r_cool_sat  <= cool_x >= 33'(COOL_MAX * COOL_STEP);
            r_cool_prod <= 37'(cool_x[17:0]) * 37'(COOL_RECIP);
            r_diff      <= $signed({1'b0, r_reading}) - $signed({1'b0, r_avg});
        end
        if (i_cmd.mul) begin
            r_dg    <= PGW'(r_diff) * PGW'($signed({1'b0, r_gain}));
            r_cgain <= cg_full[PW+3:2];
            r_cool  <= r_cool_sat ? 6'(COOL_MAX) : r_cool_prod[COOL_SHIFT+5:COOL_SHIFT];
        end
        if (i_cmd.div) begin
            r_dg_prod <= QPW'(dg_mag) * QPW'(DIV10_RECIP);
            r_dg_neg  <= r_dg[PGW-1];
            r_cc      <= 15'(i_cfg.power_ceiling) * 15'(r_cool);
        end
        if (i_cmd.avg) begin
            r_spend_prod <= 39'(cc12) * 39'(DIV10_RECIP);
        end
        if (i_cmd.lin) begin
            r_lin   <= LW'($signed({1'b0, r_avg})) * LW'(i_cfg.line_slope_q8)
                     + LW'($signed({1'b0, i_cfg.line_intercept, 8'h00}));
            r_spend <= r_spend_prod[DIV10_SHIFT+15:DIV10_SHIFT];
        end
        if (i_cmd.load_out) begin
            r_out_delay <= r_delay;
            r_out_avg   <= r_avg;
        end
    end

    assign o_firing_delay   = r_out_delay;
    assign o_smoothed_power = 12'(r_out_avg);
    assign o_firing_enabled = r_out_delay < OFF_DELAY;

endmodule

// File: rtl/core/power_to_phase_delay_mapper.sv
// Top level of the power to phase delay mapper: configuration registers and core.
// After an input transaction is accepted, the sequencer steps the single shared
// datapath through its gain, multiply, divide, average, linear and update steps,
// then loads the output register; no new input is taken until that load is done.
// The output register lets the next input be taken while a result waits.
// Synchronous active-low reset restores the register defaults and clears the state.
module power_to_phase_delay_mapper #(
    parameter int TIME_BITS  = 24,
    parameter int POWER_BITS = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [POWER_BITS-1:0]            i_power_reading,
    input  logic [TIME_BITS-1:0]             i_timestamp,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [8:0]                       o_firing_delay,
    output logic [11:0]                      o_smoothed_power,
    output logic                             o_firing_enabled,
    input  logic                             i_cfg_we,
    input  logic [ppdm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ppdm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ppdm_pkg::*;

    t_cfg    r_cfg;
    t_dp_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.power_ceiling  <= RST_POWER_CEILING;
            r_cfg.shortest_delay <= RST_SHORTEST_DELAY;
            r_cfg.longest_delay  <= RST_LONGEST_DELAY;
            r_cfg.line_intercept <= RST_LINE_INTERCEPT;
            r_cfg.line_slope_q8  <= RST_LINE_SLOPE_Q8;
            r_cfg.setting_mode   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_POWER_CEILING:  r_cfg.power_ceiling  <= i_cfg_data[8:0];
                CFG_SHORTEST_DELAY: r_cfg.shortest_delay <= i_cfg_data[5:0];
                CFG_LONGEST_DELAY:  r_cfg.longest_delay  <= i_cfg_data[7:0];
                CFG_LINE_INTERCEPT: r_cfg.line_intercept <= i_cfg_data[9:0];
                CFG_LINE_SLOPE_Q8:  r_cfg.line_slope_q8  <= $signed(i_cfg_data[12:0]);
                CFG_SETTING_MODE:   r_cfg.setting_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    ppdm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    ppdm_dp #(
        .TIME_BITS  (TIME_BITS),
        .POWER_BITS (POWER_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_cfg            (r_cfg),
        .i_power_reading  (i_power_reading),
        .i_timestamp      (i_timestamp),
        .o_firing_delay   (o_firing_delay),
        .o_smoothed_power (o_smoothed_power),
        .o_firing_enabled (o_firing_enabled)
    );

endmodule
